// File: hw/rtl/ugpb_pkg.sv
// Shared types, constants and helpers for the uniform grid primitive binner.
// No dependencies.
package ugpb_pkg;

   localparam int MAX_CELLS_X = 8;
   localparam int MAX_CELLS_Y = 8;

   localparam int COORD_W = 16;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int ACC_W   = DIFF_W + 5;
   localparam int CNT_W   = 4;
   localparam int IDX_W   = 3;

   localparam logic [1:0] OP_TRI   = 2'd0;
   localparam logic [1:0] OP_EDGE  = 2'd1;
   localparam logic [1:0] OP_POINT = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [2:0] CSR_MIN_X   = 3'd0;
   localparam logic [2:0] CSR_MAX_X   = 3'd1;
   localparam logic [2:0] CSR_MIN_Y   = 3'd2;
   localparam logic [2:0] CSR_MAX_Y   = 3'd3;
   localparam logic [2:0] CSR_CELLS_X = 3'd4;
   localparam logic [2:0] CSR_CELLS_Y = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] idx;
   } bit_pos_type;

   // lowest set bit of mask at or above position from
   function automatic bit_pos_type first_from(input logic [7:0] mask,
                                              input logic [3:0] from);
      bit_pos_type r;
      r.found = 1'b0;
      r.idx   = '0;
      for (int i = 7; i >= 0; i--) begin
         if (mask[i] && (4'(i) >= from)) begin
            r.found = 1'b1;
            r.idx   = IDX_W'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] clamp_cells(input logic [CNT_W-1:0] v,
                                                    input logic [CNT_W-1:0] maxc);
      logic [CNT_W-1:0] r;
      r = v;
      if (v == '0) r = CNT_W'(1);
      else if (v > maxc) r = maxc;
      return r;
   endfunction

endpackage

// File: hw/rtl/ugpb_cell_test.sv
// Shared border test unit: checks one cell index against the scaled box.
// Depends on ugpb_pkg.
module ugpb_cell_test (
   input  logic signed [ugpb_pkg::ACC_W-1:0] lo_scaled,
   input  logic signed [ugpb_pkg::ACC_W-1:0] hi_scaled,
   input  logic signed [ugpb_pkg::ACC_W-1:0] acc,
   input  logic signed [ugpb_pkg::ACC_W-1:0] span,
   output logic                              hit,
   output logic signed [ugpb_pkg::ACC_W-1:0] acc_next
);

   // acc holds span*k; acc_next is span*(k+1)
   assign acc_next = acc + span;
   assign hit      = (lo_scaled <= acc_next) && (hi_scaled >= acc);

endmodule

// File: hw/rtl/uniform_grid_primitive_binner.sv
// Uniform grid binner top level: bounding box, per-axis cell scan, cell emission.
// Sequence: the request is accepted in IDLE, then per axis a PREP setup state and a SCAN over
// the n cells; EMIT then moves to the first hit cell unless it is (0,0) or nothing is hit, and
// outputs one cell per cycle when not stalled. Opcode 3 is accepted and dropped with no output.
// Throughput is set by the single shared border test unit and the unstalled one-cell-per-cycle output.
// Reset is synchronous: config registers return to their defaults, no result pending.
module uniform_grid_primitive_binner (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_opcode,
   input  logic [15:0]         req_item_index,
   input  logic signed [15:0]  req_ax,
   input  logic signed [15:0]  req_ay,
   input  logic signed [15:0]  req_bx,
   input  logic signed [15:0]  req_by_coord,
   input  logic signed [15:0]  req_cx,
   input  logic signed [15:0]  req_cy,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_cell_col,
   output logic [2:0]          rsp_cell_row,
   output logic [15:0]         rsp_prim_index,
   output logic [1:0]          rsp_prim_kind,
   output logic                rsp_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_data
);

   localparam int AW = ugpb_pkg::ACC_W;
   localparam int DW = ugpb_pkg::DIFF_W;
   localparam int NW = ugpb_pkg::CNT_W;

   logic signed [15:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic [NW-1:0]      cells_x_ff, cells_y_ff;

   ugpb_pkg::state_type state_ff, state_in;
   logic               axis_ff, axis_in;
   logic [2:0]         k_ff, k_in;
   logic signed [AW-1:0] lo_sc_ff, lo_sc_in, hi_sc_ff, hi_sc_in;
   logic signed [AW-1:0] acc_ff, acc_in, span_ff, span_in;
   logic [7:0]         xmask_ff, xmask_in, ymask_ff, ymask_in;
   logic signed [15:0] lox_ff, lox_in, hix_ff, hix_in, loy_ff, loy_in, hiy_ff, hiy_in;
   logic [15:0]        index_ff, index_in;
   logic [1:0]         kind_ff, kind_in;
   logic [2:0]         col_ff, col_in, row_ff, row_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic [15:0]        out_index_ff, out_index_in;
   logic [1:0]         out_kind_ff, out_kind_in;
   logic               out_last_ff, out_last_in;

   logic [NW-1:0]      nx, ny, n_cur;
   logic signed [15:0] mn_cur, mx_cur, lo_cur, hi_cur;
   logic signed [DW-1:0] d_lo, d_hi, d_span;
   logic signed [AW-1:0] n_ext, lo_prod, hi_prod;
   logic               hit;
   logic signed [AW-1:0] acc_next;
   logic               req_acc, out_free;
   logic signed [15:0] bx_lo, bx_hi, by_lo, by_hi, cx_lo, cx_hi, cy_lo, cy_hi;
   ugpb_pkg::bit_pos_type nr, nc, fr, fc;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff   <= 16'sd0;
         max_x_ff   <= 16'sd4095;
         min_y_ff   <= 16'sd0;
         max_y_ff   <= 16'sd4095;
         cells_x_ff <= NW'(8);
         cells_y_ff <= NW'(8);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ugpb_pkg::CSR_MIN_X:   min_x_ff   <= csr_data;
            ugpb_pkg::CSR_MAX_X:   max_x_ff   <= csr_data;
            ugpb_pkg::CSR_MIN_Y:   min_y_ff   <= csr_data;
            ugpb_pkg::CSR_MAX_Y:   max_y_ff   <= csr_data;
            ugpb_pkg::CSR_CELLS_X: cells_x_ff <= csr_data[NW-1:0];
            ugpb_pkg::CSR_CELLS_Y: cells_y_ff <= csr_data[NW-1:0];
            default: ;
         endcase
      end
   end

   assign nx = ugpb_pkg::clamp_cells(cells_x_ff, NW'(ugpb_pkg::MAX_CELLS_X));
   assign ny = ugpb_pkg::clamp_cells(cells_y_ff, NW'(ugpb_pkg::MAX_CELLS_Y));

   // bounding box of the incoming primitive
   always_comb begin
      bx_lo = req_ax; bx_hi = req_ax;
      by_lo = req_ay; by_hi = req_ay;
      if (req_opcode == ugpb_pkg::OP_TRI || req_opcode == ugpb_pkg::OP_EDGE) begin
         if (req_bx < bx_lo) bx_lo = req_bx;
         if (req_bx > bx_hi) bx_hi = req_bx;
         if (req_by_coord < by_lo) by_lo = req_by_coord;
         if (req_by_coord > by_hi) by_hi = req_by_coord;
      end
      cx_lo = bx_lo; cx_hi = bx_hi;
      cy_lo = by_lo; cy_hi = by_hi;
      if (req_opcode == ugpb_pkg::OP_TRI) begin
         if (req_cx < cx_lo) cx_lo = req_cx;
         if (req_cx > cx_hi) cx_hi = req_cx;
         if (req_cy < cy_lo) cy_lo = req_cy;
         if (req_cy > cy_hi) cy_hi = req_cy;
      end
   end

   // axis operand select and scaling
   assign n_cur  = axis_ff ? ny : nx;
   assign mn_cur = axis_ff ? min_y_ff : min_x_ff;
   assign mx_cur = axis_ff ? max_y_ff : max_x_ff;
   assign lo_cur = axis_ff ? loy_ff : lox_ff;
   assign hi_cur = axis_ff ? hiy_ff : hix_ff;

   assign d_lo   = DW'(lo_cur) - DW'(mn_cur);
   assign d_hi   = DW'(hi_cur) - DW'(mn_cur);
   assign d_span = DW'(mx_cur) - DW'(mn_cur);
   assign n_ext  = {{(AW-NW){1'b0}}, n_cur};
   assign lo_prod = n_ext * AW'(d_lo);
   assign hi_prod = n_ext * AW'(d_hi);

   ugpb_cell_test u_test (
      .lo_scaled (lo_sc_ff),
      .hi_scaled (hi_sc_ff),
      .acc       (acc_ff),
      .span      (span_ff),
      .hit       (hit),
      .acc_next  (acc_next)
   );

   assign req_stall = (state_ff != ugpb_pkg::ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign fc = ugpb_pkg::first_from(xmask_ff, 4'd0);
   assign fr = ugpb_pkg::first_from(ymask_ff, 4'd0);
   assign nc = ugpb_pkg::first_from(xmask_ff, {1'b0, col_ff} + 4'd1);
   assign nr = ugpb_pkg::first_from(ymask_ff, {1'b0, row_ff} + 4'd1);

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      k_in     = k_ff;
      lo_sc_in = lo_sc_ff;
      hi_sc_in = hi_sc_ff;
      acc_in   = acc_ff;
      span_in  = span_ff;
      xmask_in = xmask_ff;
      ymask_in = ymask_ff;
      lox_in = lox_ff; hix_in = hix_ff; loy_in = loy_ff; hiy_in = hiy_ff;
      index_in = index_ff;
      kind_in  = kind_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_index_in = out_index_ff;
      out_kind_in  = out_kind_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         ugpb_pkg::ST_IDLE: begin
            if (req_acc && req_opcode != ugpb_pkg::OP_NONE) begin
               lox_in = cx_lo; hix_in = cx_hi;
               loy_in = cy_lo; hiy_in = cy_hi;
               index_in = req_item_index;
               kind_in  = req_opcode;
               axis_in  = 1'b0;
               xmask_in = '0;
               ymask_in = '0;
               state_in = ugpb_pkg::ST_PREP;
            end
         end
         ugpb_pkg::ST_PREP: begin
            lo_sc_in = lo_prod;
            hi_sc_in = hi_prod;
            span_in  = AW'(d_span);
            acc_in   = '0;
            k_in     = '0;
            state_in = ugpb_pkg::ST_SCAN;
         end
         ugpb_pkg::ST_SCAN: begin
            if (axis_ff) ymask_in[k_ff] = hit;
            else         xmask_in[k_ff] = hit;
            acc_in = acc_next;
            k_in   = k_ff + 3'd1;
            if ({1'b0, k_ff} == n_cur - NW'(1)) begin
               if (axis_ff) begin
                  state_in = ugpb_pkg::ST_EMIT;
                  col_in   = '0;
                  row_in   = '0;
               end else begin
                  axis_in  = 1'b1;
                  state_in = ugpb_pkg::ST_PREP;
               end
            end
         end
         ugpb_pkg::ST_EMIT: begin
            if (!fc.found || !fr.found) begin
               state_in = ugpb_pkg::ST_IDLE;
            end else begin
               // first pass: move to the lowest set column and row
               if (!xmask_ff[col_ff] || !ymask_ff[row_ff]) begin
                  col_in = xmask_ff[col_ff] ? col_ff : fc.idx;
                  row_in = ymask_ff[row_ff] ? row_ff : fr.idx;
                  if (!xmask_ff[col_ff] && ymask_ff[row_ff]) row_in = fr.idx;
               end else if (out_free) begin
                  rsp_valid_in = 1'b1;
                  out_col_in   = col_ff;
                  out_row_in   = row_ff;
                  out_index_in = index_ff;
                  out_kind_in  = kind_ff;
                  out_last_in  = !nr.found && !nc.found;
                  if (nr.found) begin
                     row_in = nr.idx;
                  end else if (nc.found) begin
                     row_in = fr.idx;
                     col_in = nc.idx;
                  end else begin
                     state_in = ugpb_pkg::ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ugpb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ugpb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff  <= axis_in;
      k_ff     <= k_in;
      lo_sc_ff <= lo_sc_in;
      hi_sc_ff <= hi_sc_in;
      acc_ff   <= acc_in;
      span_ff  <= span_in;
      xmask_ff <= xmask_in;
      ymask_ff <= ymask_in;
      lox_ff <= lox_in; hix_ff <= hix_in; loy_ff <= loy_in; hiy_ff <= hiy_in;
      index_ff <= index_in;
      kind_ff  <= kind_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      out_col_ff   <= out_col_in;
      out_row_ff   <= out_row_in;
      out_index_ff <= out_index_in;
      out_kind_ff  <= out_kind_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_col   = out_col_ff;
   assign rsp_cell_row   = out_row_ff;
   assign rsp_prim_index = out_index_ff;
   assign rsp_prim_kind  = out_kind_ff;
   assign rsp_last       = out_last_ff;

   a_cell_in_grid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, out_col_ff} < nx) && ({1'b0, out_row_ff} < ny))
      else $error("emitted cell outside grid");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ugpb_pkg::ST_SCAN) |-> ({1'b0, k_ff} < n_cur))
      else $error("scan index past cell count");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_opcode != ugpb_pkg::OP_NONE) |=> (state_ff == ugpb_pkg::ST_PREP))
      else $error("accepted item did not start");

   a_emit_marked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ugpb_pkg::ST_EMIT && state_in == ugpb_pkg::ST_IDLE && rsp_valid_in
       && !(rsp_valid_ff && rsp_stall)) |=> rsp_last)
      else $error("final cell not marked last");

endmodule
